[design/smt_pkg.sv]
// Package for the sorted multiset table: command codes, status codes, cursor places.
// Used by every module of the block.
`default_nettype none
package smt_pkg;
    localparam int CapacityDefault = 64;
    localparam logic [30:0] MaxCount = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        CMD_INSERT = 4'd0, CMD_DELETE = 4'd1, CMD_COUNT = 4'd2, CMD_INDEX = 4'd3,
        CMD_AT = 4'd4, CMD_CRESET = 4'd5, CMD_CNEXT = 4'd6, CMD_CPREV = 4'd7,
        CMD_CGET = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0, ST_FULL = 2'd1, ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PL_START = 2'd0, PL_ON = 2'd1, PL_END = 2'd2
    } t_place;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_UPDATE, S_REPORT, S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input word
        logic search;   // compare all cells against the key
        logic update;   // apply insert, delete or cursor move
        logic report;   // search again for the reported element
        logic finish;   // form the result word
    } t_ctrl;
endpackage
`default_nettype wire

[design/smt_ctrl.sv]
// Controller of the sorted multiset table: steps each word through search,
// update, report and output. Depends on smt_pkg.
`default_nettype none
module smt_ctrl
    import smt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_ctrl      o_ctrl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SEARCH;
            S_SEARCH: n_state = S_UPDATE;
            S_UPDATE: n_state = S_REPORT;
            S_REPORT: n_state = S_OUT;
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_ctrl.load = i_in_valid;
            end
            S_SEARCH: o_ctrl.search = 1'b1;
            S_UPDATE: o_ctrl.update = 1'b1;
            S_REPORT: o_ctrl.report = 1'b1;
            S_OUT: begin
                o_out_valid = 1'b1;
                o_ctrl.finish = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |=> r_state == S_SEARCH) else $error("load did not start search");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall) else $error("accept while busy");
endmodule
`default_nettype wire

[design/smt_datapath.sv]
// Datapath of the sorted multiset table: a row of cells that compare against
// a key in parallel and shift for insert and delete. Depends on smt_pkg.
`default_nettype none
module smt_datapath
    import smt_pkg::*;
#(
    parameter int Capacity = CapacityDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ctrl              i_ctrl,
    input  wire logic [31:0]        i_undef,
    input  wire logic [3:0]         i_command,
    input  wire logic signed [31:0] i_element,
    input  wire logic signed [31:0] i_amount,
    input  wire logic signed [31:0] i_position,
    output logic signed [31:0]      o_out_element,
    output logic [30:0]             o_out_count,
    output logic signed [7:0]       o_out_rank,
    output logic                    o_flag,
    output logic [6:0]              o_distinct_count,
    output logic [30:0]             o_count_sum,
    output logic [1:0]              o_status
);
    localparam int IW = $clog2(Capacity);
    localparam int OW = $clog2(Capacity + 1);
    localparam int SW = 31 + OW;

    logic [31:0] r_elem [Capacity];
    logic [30:0] r_cnt  [Capacity];
    logic [OW-1:0] r_occ;
    logic [SW-1:0] r_sum;        // exact sum of the counts; saturated on output
    t_place      r_place;
    logic [31:0] r_cur;

    logic [3:0]  r_cmd;
    logic [31:0] r_key, r_amt, r_pos;
    logic [OW-1:0] r_lpos;       // first entry >= key
    logic        r_hit;
    logic [1:0]  r_stat;
    logic        r_flag;
    logic        r_valid_rep;    // something to report
    logic [OW-1:0] r_rpos;
    logic [31:0] w_oelem;
    logic [30:0] w_ocnt;

    // Cell compare: each cell reports whether it is valid and below the key, and whether it is valid and equal to it.
    logic [Capacity-1:0] w_less;
    logic [Capacity-1:0] w_eq;
    logic [OW-1:0] w_lpos;
    logic          w_hit;
    logic [31:0]   w_skey;

    always_comb begin
        w_skey = i_ctrl.report && (r_cmd == CMD_CNEXT || r_cmd == CMD_CPREV ||
                 r_cmd == CMD_CGET) ? r_cur : r_key;
        if (i_ctrl.search && (r_cmd == CMD_CNEXT || r_cmd == CMD_CPREV)) w_skey = r_cur;
        for (int i = 0; i < Capacity; i++) begin
            w_less[i] = (OW'(i) < r_occ) &&
                        ($signed(r_elem[i]) < $signed(w_skey));
            w_eq[i]   = (OW'(i) < r_occ) && (r_elem[i] == w_skey);
        end
        // Sorted table: the less-than bits form a thermometer code.
        w_lpos = OW'($countones(w_less));
        w_hit = |w_eq;
    end

    logic          w_amt_ok;
    logic [31:0]   w_sat;
    logic [30:0]   w_hcnt;
    logic [30:0]   w_newcnt;
    logic [IW-1:0] w_li;
    logic [OW-1:0] w_next_p, w_prev_p;
    logic          w_flag;
    t_status       w_stat;
    logic          w_rep;
    logic [OW-1:0] w_rpos;

    assign w_amt_ok = (r_amt != 32'd0) && !r_amt[31];
    assign w_li = r_lpos[IW-1:0];
    assign w_hcnt = r_cnt[w_li];
    assign w_sat = {1'b0, w_hcnt} + r_amt;
    assign w_newcnt = w_sat[31] ? MaxCount : w_sat[30:0];

    // Slot the cursor lands on: next skips the cursor's own element when held.
    assign w_next_p = (r_place == PL_START) ? '0 :
                      (r_place == PL_ON) ? r_lpos + OW'(r_hit) : r_occ;
    assign w_prev_p = (r_place == PL_END) ? r_occ :
                      (r_place == PL_ON) ? r_lpos : '0;
    assign w_flag = (r_cmd == CMD_CNEXT && w_next_p < r_occ) ||
                    (r_cmd == CMD_CPREV && w_prev_p != '0);

    always_comb begin
        case (r_cmd)
            CMD_INSERT: begin
                if (!w_amt_ok || r_key == i_undef) w_stat = ST_IGNORED;
                else if (!r_hit && r_occ == OW'(Capacity)) w_stat = ST_FULL;
                else w_stat = ST_DONE;
            end
            CMD_DELETE: w_stat = (!w_amt_ok || r_key == i_undef) ? ST_IGNORED : ST_DONE;
            CMD_COUNT, CMD_INDEX, CMD_AT, CMD_CRESET, CMD_CNEXT, CMD_CPREV, CMD_CGET:
                w_stat = ST_DONE;
            default: w_stat = ST_IGNORED;
        endcase
    end

    always_comb begin
        w_rpos = w_lpos;
        case (r_cmd)
            CMD_INSERT, CMD_DELETE, CMD_COUNT, CMD_INDEX:
                w_rep = w_hit && r_stat == ST_DONE;
            CMD_AT: begin
                w_rep = !r_pos[31] && (r_pos < 32'(r_occ));
                w_rpos = OW'(r_pos);
            end
            CMD_CNEXT, CMD_CPREV, CMD_CGET:
                w_rep = (r_place == PL_ON) && w_hit;
            default: w_rep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_sum <= '0;
            r_place <= PL_START;
            r_cur <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_cmd <= i_command;
                r_key <= i_element;
                r_amt <= i_amount;
                r_pos <= i_position;
            end
            if (i_ctrl.search) begin
                r_lpos <= w_lpos;
                r_hit <= w_hit;
            end
            if (i_ctrl.update) begin
                r_stat <= w_stat;
                r_flag <= w_flag;
                case (r_cmd)
                    CMD_INSERT: begin
                        if (w_stat == ST_DONE && r_hit) begin
                            r_cnt[w_li] <= w_newcnt;
                            r_sum <= r_sum - SW'(w_hcnt) + SW'(w_newcnt);
                        end else if (w_stat == ST_DONE) begin
                            for (int i = 0; i < Capacity; i++) begin
                                if (OW'(i) == r_lpos) begin
                                    r_elem[i] <= r_key;
                                    r_cnt[i] <= r_amt[30:0];
                                end else if (OW'(i) > r_lpos && i > 0) begin
                                    r_elem[i] <= r_elem[i-1];
                                    r_cnt[i] <= r_cnt[i-1];
                                end
                            end
                            r_occ <= r_occ + 1'b1;
                            r_sum <= r_sum + SW'(r_amt[30:0]);
                        end
                    end
                    CMD_DELETE: begin
                        if (w_stat == ST_DONE && r_hit) begin
                            if ({1'b0, w_hcnt} > r_amt) begin
                                r_cnt[w_li] <= w_hcnt - r_amt[30:0];
                                r_sum <= r_sum - SW'(r_amt[30:0]);
                            end else begin
                                for (int i = 0; i < Capacity - 1; i++) begin
                                    if (OW'(i) >= r_lpos) begin
                                        r_elem[i] <= r_elem[i+1];
                                        r_cnt[i] <= r_cnt[i+1];
                                    end
                                end
                                r_occ <= r_occ - 1'b1;
                                r_sum <= r_sum - SW'(w_hcnt);
                            end
                        end
                    end
                    CMD_CRESET: r_place <= PL_START;
                    CMD_CNEXT: begin
                        if (w_flag) begin
                            r_place <= PL_ON;
                            r_cur <= r_elem[w_next_p[IW-1:0]];
                        end else begin
                            r_place <= PL_END;
                        end
                    end
                    CMD_CPREV: begin
                        if (w_flag) begin
                            r_place <= PL_ON;
                            r_cur <= r_elem[IW'(w_prev_p - 1'b1)];
                        end else begin
                            r_place <= PL_START;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_ctrl.report) begin
                r_valid_rep <= w_rep;
                r_rpos <= w_rpos;
            end
        end
    end

    assign w_oelem = r_elem[r_rpos[IW-1:0]];
    assign w_ocnt  = r_cnt[r_rpos[IW-1:0]];

    always_comb begin
        o_out_element = r_valid_rep ? w_oelem : i_undef;
        o_out_count   = r_valid_rep ? w_ocnt : '0;
        o_out_rank    = r_valid_rep ? 8'(r_rpos) : 8'hFF;
        o_flag        = r_flag;
        o_distinct_count = 7'(r_occ);
        o_count_sum   = (r_sum > SW'(MaxCount)) ? MaxCount : r_sum[30:0];
        o_status      = r_stat;
    end

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(Capacity)) else $error("occupancy beyond capacity");
    a_full_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.update && r_occ == OW'(Capacity)) |=> r_occ <= OW'(Capacity))
        else $error("full table grew");
    a_flag_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.report && r_flag) |-> r_place == PL_ON) else $error("flag off element");
endmodule
`default_nettype wire

[design/sorted_multiset_table.sv]
// Sorted multiset table: the usage-level comment below describes the block.
//
// Input channel: i_in_valid / o_in_stall with fields command, element, amount,
// position. A word is accepted when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall, one result word per input word.
// After the accepting edge a command passes in turn through a parallel
// compare over all cells, the update and shift of the cell row, and a second
// compare for the reported element; the result word is then valid and holds
// until it is taken. The controller then returns to idle, so a new word is
// accepted only after the last result has been taken. While the receiver
// stalls the result holds and no new word is accepted. Reset (i_rst_n low,
// synchronous) empties the table, zeroes the total, parks the cursor at the
// start and restores the sentinel; no clearing pass is needed. The sentinel
// register must be written through i_cfg_we / i_cfg_data only while idle;
// the user is bound by this, and the block itself does not enforce it.
// Depends on smt_pkg, smt_ctrl and smt_datapath.
`default_nettype none
module sorted_multiset_table
    import smt_pkg::*;
#(
    parameter int Capacity = CapacityDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic signed [31:0] i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [3:0]         i_command,
    input  wire logic signed [31:0] i_element,
    input  wire logic signed [31:0] i_amount,
    input  wire logic signed [31:0] i_position,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_out_element,
    output logic [30:0]             o_out_count,
    output logic signed [7:0]       o_out_rank,
    output logic                    o_flag,
    output logic [6:0]              o_distinct_count,
    output logic [30:0]             o_count_sum,
    output logic [1:0]              o_status
);
    logic [31:0] r_undef;
    t_ctrl       w_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_undef <= 32'h8000_0000;
        else if (i_cfg_we) r_undef <= i_cfg_data;
    end

    smt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .o_ctrl(w_ctrl)
    );

    smt_datapath #(.Capacity(Capacity)) u_dp (
        .i_clk, .i_rst_n, .i_ctrl(w_ctrl), .i_undef(r_undef),
        .i_command, .i_element, .i_amount, .i_position,
        .o_out_element, .o_out_count, .o_out_rank, .o_flag,
        .o_distinct_count, .o_count_sum, .o_status
    );
endmodule
`default_nettype wire
